[rtl/lrtm_pkg.sv]
package lrtm_pkg;

    localparam int VAL_W = 30;
    localparam int ADDR_W = 6;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;
    localparam longint unsigned BARRETT_MU_FULL = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU = BARRETT_MU_FULL[30:0];

    localparam logic [2:0] REG_COUNT = 3'd7;

    typedef struct packed {
        logic              issue;
        logic [ADDR_W-1:0] x_addr;
        logic [ADDR_W-1:0] y_addr;
        logic [ADDR_W-1:0] w_addr;
        logic              first;
        logic              last;
        logic              y_seed;
        logic [1:0]        seed_sel;
        logic              to_out;
        logic              init_we;
        logic [ADDR_W-1:0] init_addr;
        logic              init_comp;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

    function automatic logic [VAL_W-1:0] reg_mod(input logic [VAL_W-1:0] x);
        reg_mod = (x >= MODULUS) ? x - MODULUS : x;
    endfunction

endpackage

[rtl/linear_recurrence_term_mod.sv]
// Returns f(n) mod 1000000007 for the order-4 recurrence whose weights and first four
// terms sit in configuration registers 0..7. n arrives on s_axis_tdata (0 is taken as 1);
// one result item leaves on m_axis_tdata per input item. The companion matrix is raised
// to n-1 by square-and-multiply; every 4x4 product runs through one pipelined
// multiply-reduce unit at one step per cycle: it issues all 64 multiply steps and then
// drains the pipeline, and a squaring is followed by a decision on the next bit. The next
// index is taken once the previous item has issued its final terms, while its result
// still waits on the output; a result left waiting holds the next item before its final
// dot product.
module linear_recurrence_term_mod
    import lrtm_pkg::*;
#(
    parameter int INDEX_BITS = 61
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // term_index
    input  logic [((INDEX_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // term_value
    output logic [31:0]                         m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_addr,
    input  logic [VAL_W-1:0]                    cfg_data
);

    cmd_t             cmd;
    stat_t            stat;
    logic [VAL_W-1:0] out_value;

    lrtm_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_index (s_axis_tdata[INDEX_BITS-1:0]),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrtm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_value (out_value),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, out_value};

endmodule

[rtl/lrtm_ctrl.sv]
module lrtm_ctrl
    import lrtm_pkg::*;
#(
    parameter int INDEX_BITS = 61
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [INDEX_BITS-1:0] in_index,
    output logic                  in_ready,
    input  stat_t                 stat,
    output cmd_t                  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_SQR    = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_DOT    = 3'd6;

    localparam logic [2:0] DRAIN_LOAD = 3'(DRAIN_CYCLES - 1);

    logic [2:0]            state_reg, state_next;
    logic [INDEX_BITS-1:0] p_reg, p_next;
    logic [1:0]            acc_bank_reg, acc_bank_next;
    logic [1:0]            base_bank_reg, base_bank_next;
    logic [1:0]            free_bank_reg, free_bank_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [2:0]            drain_reg, drain_next;
    logic                  after_sqr_reg, after_sqr_next;
    logic [1:0]            x_bank;

    assign in_ready = (state_reg == ST_IDLE);
    assign x_bank = (state_reg == ST_MUL) ? acc_bank_reg : base_bank_reg;

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        acc_bank_next  = acc_bank_reg;
        base_bank_next = base_bank_reg;
        free_bank_next = free_bank_reg;
        cnt_next       = cnt_reg;
        drain_next     = drain_reg;
        after_sqr_next = after_sqr_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    p_next = (in_index == '0) ? '0 : in_index - INDEX_BITS'(1);
                    acc_bank_next  = 2'd0;
                    base_bank_next = 2'd1;
                    free_bank_next = 2'd2;
                    cnt_next       = '0;
                    state_next     = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init_we   = 1'b1;
                cmd.init_addr = {(cnt_reg[4] ? base_bank_reg : acc_bank_reg), cnt_reg[3:0]};
                cmd.init_comp = cnt_reg[4];
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg[4:0] == 5'd31)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cnt_next = '0;
                if (p_reg == '0)
                begin
                    state_next = ST_DOT;
                end
                else if (p_reg[0])
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_SQR;
                end
            end
            ST_MUL, ST_SQR:
            begin
                cmd.issue  = 1'b1;
                cmd.x_addr = {x_bank, cnt_reg[5:4], cnt_reg[1:0]};
                cmd.y_addr = {base_bank_reg, cnt_reg[1:0], cnt_reg[3:2]};
                cmd.w_addr = {free_bank_reg, cnt_reg[5:4], cnt_reg[3:2]};
                cmd.first  = (cnt_reg[1:0] == 2'd0);
                cmd.last   = (cnt_reg[1:0] == 2'd3);
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    free_bank_next = x_bank;
                    if (state_reg == ST_MUL)
                    begin
                        acc_bank_next = free_bank_reg;
                    end
                    else
                    begin
                        base_bank_next = free_bank_reg;
                        p_next         = p_reg >> 1;
                    end
                    after_sqr_next = (state_reg == ST_SQR);
                    drain_next     = DRAIN_LOAD;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - 3'd1;
                cnt_next   = '0;
                if (drain_reg == 3'd0)
                begin
                    if (after_sqr_reg)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else if (p_reg[INDEX_BITS-1:1] == '0)
                    begin
                        state_next = ST_DOT;
                    end
                    else
                    begin
                        state_next = ST_SQR;
                    end
                end
            end
            ST_DOT:
            begin
                if (!stat.out_busy || cnt_reg[1:0] != 2'd0)
                begin
                    cmd.issue    = 1'b1;
                    cmd.x_addr   = {acc_bank_reg, 2'd3, cnt_reg[1:0]};
                    cmd.y_seed   = 1'b1;
                    cmd.seed_sel = cnt_reg[1:0];
                    cmd.first    = (cnt_reg[1:0] == 2'd0);
                    cmd.last     = (cnt_reg[1:0] == 2'd3);
                    cmd.to_out   = (cnt_reg[1:0] == 2'd3);
                    cnt_next     = cnt_reg + 6'd1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p_reg         <= '0;
            acc_bank_reg  <= 2'd0;
            base_bank_reg <= 2'd1;
            free_bank_reg <= 2'd2;
            cnt_reg       <= '0;
            drain_reg     <= '0;
            after_sqr_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            acc_bank_reg  <= acc_bank_next;
            base_bank_reg <= base_bank_next;
            free_bank_reg <= free_bank_next;
            cnt_reg       <= cnt_next;
            drain_reg     <= drain_next;
            after_sqr_reg <= after_sqr_next;
        end
    end

endmodule

[rtl/lrtm_dpath.sv]
module lrtm_dpath
    import lrtm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [VAL_W-1:0] cfg_data,
    input  cmd_t             cmd,
    output stat_t            stat,
    output logic             out_valid,
    output logic [VAL_W-1:0] out_value,
    input  logic             out_ready
);

    typedef struct packed {
        logic              v;
        logic              first;
        logic              last;
        logic              to_out;
        logic [ADDR_W-1:0] w_addr;
    } tag_t;

    logic [VAL_W-1:0]  cfg_reg [8];
    logic [VAL_W-1:0]  mem [48];

    logic [VAL_W-1:0]  rdx_reg, rdy_reg;
    logic              yseed1_reg;
    logic [1:0]        seedsel1_reg;
    tag_t              t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [59:0]       prod_reg, prod2_reg;
    logic [31:0]       prod3_reg;
    logic [61:0]       q2_reg;
    logic [31:0]       qp_reg;
    logic [VAL_W-1:0]  red_reg;
    logic [VAL_W-1:0]  sum_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;

    logic [VAL_W-1:0]  y_op;
    logic [60:0]       qp_full;
    logic [31:0]       r_raw;
    logic [VAL_W-1:0]  red_next;
    logic [VAL_W:0]    sum_raw;
    logic [VAL_W-1:0]  sum_next;
    logic [1:0]        init_i, init_j;
    logic [VAL_W-1:0]  init_val;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= 30'd1;
            cfg_reg[1] <= 30'd2;
            cfg_reg[2] <= 30'd3;
            cfg_reg[3] <= 30'd1;
            cfg_reg[4] <= 30'd1;
            cfg_reg[5] <= 30'd2;
            cfg_reg[6] <= 30'd5;
            cfg_reg[7] <= 30'd12;
        end
        else if (cfg_we && cfg_addr <= REG_COUNT)
        begin
            cfg_reg[cfg_addr] <= cfg_data;
        end
    end

    assign init_i = cmd.init_addr[3:2];
    assign init_j = cmd.init_addr[1:0];

    always_comb
    begin
        if (cmd.init_comp)
        begin
            if (init_i == 2'd0)
            begin
                init_val = reg_mod(cfg_reg[{1'b0, init_j}]);
            end
            else
            begin
                init_val = (init_j == init_i - 2'd1) ? 30'd1 : 30'd0;
            end
        end
        else
        begin
            init_val = (init_i == init_j) ? 30'd1 : 30'd0;
        end
    end

    assign mem_we    = cmd.init_we || (t5_reg.v && t5_reg.last && !t5_reg.to_out);
    assign mem_waddr = cmd.init_we ? cmd.init_addr : t5_reg.w_addr;
    assign mem_wdata = cmd.init_we ? init_val : sum_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdx_reg <= mem[cmd.x_addr];
        rdy_reg <= mem[cmd.y_addr];
    end

    assign y_op = yseed1_reg ? reg_mod(cfg_reg[{1'b1, ~seedsel1_reg}]) : rdy_reg;

    assign qp_full = q2_reg[61:31] * MODULUS;
    assign r_raw   = prod3_reg - qp_reg;

    always_comb
    begin
        if (r_raw >= {1'b0, MODULUS, 1'b0})
        begin
            red_next = VAL_W'(r_raw - {1'b0, MODULUS, 1'b0});
        end
        else if (r_raw >= {2'b0, MODULUS})
        begin
            red_next = VAL_W'(r_raw - {2'b0, MODULUS});
        end
        else
        begin
            red_next = r_raw[VAL_W-1:0];
        end
    end

    assign sum_raw  = (t5_reg.first ? {(VAL_W+1){1'b0}} : {1'b0, sum_reg}) + {1'b0, red_reg};
    assign sum_next = (sum_raw >= {1'b0, MODULUS}) ? VAL_W'(sum_raw - {1'b0, MODULUS})
                                                   : sum_raw[VAL_W-1:0];

    always_ff @(posedge clk)
    begin
        yseed1_reg   <= cmd.y_seed;
        seedsel1_reg <= cmd.seed_sel;
        prod_reg     <= rdx_reg * y_op;
        q2_reg       <= prod_reg[59:29] * BARRETT_MU;
        prod2_reg    <= prod_reg;
        qp_reg       <= qp_full[31:0];
        prod3_reg    <= prod2_reg[31:0];
        red_reg      <= red_next;
        if (t5_reg.v)
        begin
            sum_reg <= sum_next;
        end
        if (t5_reg.v && t5_reg.to_out)
        begin
            out_value_reg <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg        <= '0;
            t2_reg        <= '0;
            t3_reg        <= '0;
            t4_reg        <= '0;
            t5_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            t1_reg <= '{v: cmd.issue, first: cmd.first, last: cmd.last,
                        to_out: cmd.to_out, w_addr: cmd.w_addr};
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
            if (t5_reg.v && t5_reg.to_out && t5_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign stat.out_busy = out_valid_reg;

endmodule

[test/tb_linear_recurrence_term_mod.sv]
module tb_linear_recurrence_term_mod;
    import lrtm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = 61;
    localparam longint unsigned PRIME = 64'd1000000007;
    localparam logic [2:0] REG_COEF_ONE = 3'd0;
    localparam logic [2:0] REG_SEED_FIRST = 3'd4;
    localparam logic [2:0] REG_SEED_FOURTH = 3'd7;

    typedef logic [15:0][29:0] mat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_addr = '0;
    logic [VAL_W-1:0] cfg_data = '0;

    logic [29:0] recurrence_regs [8];
    logic [29:0] pending_terms [$];
    int err_count = 0;
    bit calm = 1'b0;

    linear_recurrence_term_mod #(.INDEX_BITS(IDX_W)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [29:0] mulmod(input logic [29:0] a, input logic [29:0] b);
        longint unsigned p;
        p = longint'(a) * longint'(b);
        mulmod = 30'(p % PRIME);
    endfunction

    function automatic logic [29:0] reduced_reg(input int k);
        reduced_reg = 30'(longint'(recurrence_regs[k]) % PRIME);
    endfunction

    function automatic mat_t mat_product(input mat_t x, input mat_t y);
        mat_t r;
        longint unsigned acc;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += mulmod(x[i*4+k], y[k*4+j]);
                r[i*4+j] = 30'(acc % PRIME);
            end
        end
        mat_product = r;
    endfunction

    function automatic logic [29:0] predict_term(input logic [63:0] raw);
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] power;
        mat_t acc;
        mat_t base;
        longint unsigned sum;
        n = raw[IDX_W-1:0];
        if (n == 0)
            n = 1;
        power = n - 1;
        acc = '0;
        base = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc[i*5] = 30'd1;
            base[i] = reduced_reg(i);
        end
        base[4] = 30'd1;
        base[9] = 30'd1;
        base[14] = 30'd1;
        for (int b = 0; b < IDX_W; b++)
        begin
            if (power[b])
                acc = mat_product(acc, base);
            base = mat_product(base, base);
        end
        sum = 0;
        for (int k = 0; k < 4; k++)
            sum += mulmod(acc[12+k], reduced_reg(7-k));
        predict_term = 30'(sum % PRIME);
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_terms.size() == 0)
                report($sformatf("unexpected term %0d", m_axis_tdata));
            else if (m_axis_tdata !== {2'b00, pending_terms[0]})
                report($sformatf("term_value %0d, want %0d", m_axis_tdata,
                                 pending_terms.pop_front()));
            else
                void'(pending_terms.pop_front());
        end
    end

    always
    begin
        @(posedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    task automatic send_index(input logic [63:0] n);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= n;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_terms = {pending_terms, predict_term(n)};
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_terms.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [29:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        recurrence_regs[idx] = value;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [29:0] value);
        drain();
        for (int r = REG_COEF_ONE; r <= REG_SEED_FOURTH; r++)
            write_reg(3'(r), value);
    endtask

    function automatic logic [63:0] random_index();
        int len;
        logic [63:0] n;
        len = $urandom_range(1, IDX_W);
        if (len > 40 && $urandom_range(0, 2) != 0)
            len = $urandom_range(1, 24);
        n = {$urandom, $urandom};
        n = n & ((64'd1 << len) - 1);
        n[len-1] = 1'b1;
        if ($urandom_range(0, 30) == 0)
            n = '0;
        random_index = n;
    endfunction

    task automatic test_reset_defaults;
        for (int n = 0; n <= 10; n++)
            send_index(64'(n));
        send_index(64'd1 << (IDX_W - 1));
        send_index((64'd1 << IDX_W) - 1);
    endtask

    task automatic test_register_extremes;
        write_all(30'd0);
        send_index(64'd1);
        send_index(64'd9);
        write_all(30'h3FFF_FFFF);
        send_index(64'd0);
        send_index(64'd4);
        send_index(64'd77);
        send_index((64'd1 << IDX_W) - 1);
        write_all(30'(PRIME - 1));
        send_index(64'd2);
        send_index(64'd6);
        send_index(64'h0AAA_AAAA_AAAA_AAAA);
        write_all(30'(PRIME));
        send_index(64'd3);
        send_index(64'd12);
    endtask

    task automatic test_random_terms;
        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            for (int r = REG_COEF_ONE; r <= REG_SEED_FOURTH; r++)
                write_reg(3'(r), 30'($urandom));
            if (phase == 2)
                write_reg(REG_SEED_FIRST, 30'h3FFF_FFFF);
            if (phase == 4)
                calm = 1'b1;
            for (int i = 0; i < 16; i++)
            begin
                if (phase == 1 && i == 10)
                    drain();
                send_index(random_index());
            end
        end
    endtask

    initial
    begin
        recurrence_regs = '{30'd1, 30'd2, 30'd3, 30'd1, 30'd1, 30'd2, 30'd5, 30'd12};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_terms();
        drain();
        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(64'd150_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
